@@ rtl/core/wpc_pkg.sv @@
// Package for the word pattern canonicalizer: label table, register map and widths.
// No dependencies; used by wpc_engine and word_pattern_canonicalizer.
`default_nettype none
package wpc_pkg;
    localparam int DefMaxLen = 32;
    localparam int AddrW     = 3;
    localparam logic [AddrW-1:0] RegFoldCase = 3'd0;
    localparam logic [AddrW-1:0] RegGroup    = 3'd4;

    function automatic logic [6:0] label_at(input logic [5:0] k);
        logic [6:0] r;
        begin
            r = 7'd0;
            if (k < 6'd26)
                r = 7'd97 + {1'b0, k};
            else if (k < 6'd52)
                r = 7'd65 + {1'b0, k - 6'd26};
            else if (k < 6'd62)
                r = 7'd48 + {1'b0, k - 6'd52};
            else if (k == 6'd62)
                r = 7'd95;
            else
                r = 7'd45;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/wpc_engine.sv @@
// Sequencer and memories of the word pattern canonicalizer.
// Depends on wpc_pkg.
`default_nettype none
module wpc_engine
    import wpc_pkg::*;
#(
    parameter int MAX_LEN = DefMaxLen
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] character,
    input  wire logic       last_char,
    input  wire logic       fold_case,
    input  wire logic       group_by_count,
    output logic            busy,
    output logic            valid,
    output logic [6:0]      canonical_char,
    output logic            last_out
);
    localparam int IW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOOK   = 4'd1;
    localparam logic [3:0] S_TRD    = 4'd2;
    localparam logic [3:0] S_TUPD   = 4'd3;
    localparam logic [3:0] S_EMRD   = 4'd4;
    localparam logic [3:0] S_EMLB   = 4'd5;
    localparam logic [3:0] S_EMOUT  = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;
    localparam logic [3:0] S_SCANW  = 4'd8;
    localparam logic [3:0] S_GEMIT  = 4'd9;
    localparam logic [3:0] S_CLEAR  = 4'd10;
    localparam logic [3:0] S_CLRW   = 4'd11;

    // Memories: per-position characters, per-byte labels, per-label tallies.
    logic [7:0]    word_mem  [MAX_LEN];
    logic [5:0]    label_mem [256];
    logic [CW-1:0] tally_mem [MAX_LEN];
    logic [255:0]  lvalid_reg;

    logic [3:0]    state_reg;
    logic [7:0]    ch_reg;
    logic          last_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] dcnt_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] bestv_reg;
    logic [CW-1:0] rep_reg;
    logic [IW-1:0] best_idx_reg;
    logic          found_reg;

    logic [7:0]    word_q;
    logic [5:0]    label_q;
    logic [CW-1:0] tally_q;
    logic [IW-1:0] word_ra;
    logic [7:0]    label_ra;
    logic [IW-1:0] tally_ra;
    logic          word_we;
    logic          label_we;
    logic          tally_we;
    logic [IW-1:0] tally_wa;
    logic [CW-1:0] tally_wd;
    logic [6:0]    out_next;
    logic          out_v_next;
    logic          out_l_next;
    logic [7:0]    cin;

    assign busy = (state_reg != S_IDLE);
    assign cin = (fold_case && character >= 8'h41 && character <= 8'h5A)
               ? character + 8'h20 : character;

    always_ff @(posedge clk)
    begin
        if (word_we)
            word_mem[len_reg[IW-1:0]] <= ch_reg;
        if (label_we)
            label_mem[ch_reg] <= 6'(dcnt_reg);
        if (tally_we)
            tally_mem[tally_wa] <= tally_wd;
        word_q  <= word_mem[word_ra];
        label_q <= label_mem[label_ra];
        tally_q <= tally_mem[tally_ra];
    end

    // Memory address and write controls.
    always_comb
    begin
        word_ra  = idx_reg[IW-1:0];
        label_ra = (state_reg == S_EMLB) ? word_q : ch_reg;
        tally_ra = idx_reg[IW-1:0];
        word_we  = 1'b0;
        label_we = 1'b0;
        tally_we = 1'b0;
        tally_wa = label_q[IW-1:0];
        tally_wd = tally_q + 1'b1;
        case (state_reg)
            S_LOOK:
            begin
                if (len_reg < CW'(MAX_LEN))
                begin
                    word_we = 1'b1;
                    if (!lvalid_reg[ch_reg])
                    begin
                        label_we = 1'b1;
                        tally_we = 1'b1;
                        tally_wa = dcnt_reg[IW-1:0];
                        tally_wd = CW'(1);
                    end
                end
            end
            S_TRD:
                tally_ra = label_q[IW-1:0];
            S_TUPD:
                tally_we = 1'b1;
            S_GEMIT:
            begin
                if (rep_reg == CW'(1))
                begin
                    // The entry at the best place takes the value at k before k moves on.
                    tally_we = 1'b1;
                    tally_wa = best_idx_reg;
                    tally_wd = tally_q;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            dcnt_reg   <= '0;
            lvalid_reg <= '0;
            valid      <= 1'b0;
        end
        else
        begin
            valid <= out_v_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        ch_reg    <= cin;
                        last_reg  <= last_char;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (len_reg < CW'(MAX_LEN))
                    begin
                        len_reg <= len_reg + 1'b1;
                        if (!lvalid_reg[ch_reg])
                        begin
                            lvalid_reg[ch_reg] <= 1'b1;
                            dcnt_reg <= dcnt_reg + 1'b1;
                            state_reg <= S_CLEAR;
                        end
                        else
                            state_reg <= S_TRD;
                    end
                    else
                        state_reg <= S_CLEAR;
                end
                S_TRD:
                    state_reg <= S_TUPD;
                S_TUPD:
                    state_reg <= S_CLEAR;
                S_CLEAR:
                begin
                    idx_reg <= '0;
                    k_reg   <= '0;
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (group_by_count)
                    begin
                        bestv_reg <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (dcnt_reg == '0) ? S_CLRW : S_SCAN;
                    end
                    else
                        state_reg <= (len_reg == '0) ? S_CLRW : S_EMRD;
                end
                S_EMRD:
                    state_reg <= S_EMLB;
                S_EMLB:
                    state_reg <= S_EMOUT;
                S_EMOUT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == len_reg) ? S_CLRW : S_EMRD;
                end
                S_SCAN:
                begin
                    // Reads issue one a cycle; idx_reg runs from k to dcnt.
                    if (idx_reg == '0 && !found_reg)
                        idx_reg <= k_reg;
                    else
                        idx_reg <= idx_reg + 1'b1;
                    found_reg <= 1'b1;
                    if (found_reg && idx_reg != k_reg)
                    begin
                        if (tally_q > bestv_reg)
                        begin
                            bestv_reg <= tally_q;
                            best_idx_reg <= IW'(idx_reg - 1'b1);
                        end
                    end
                    else if (found_reg)
                    begin
                        bestv_reg <= '0;
                    end
                    if (found_reg && idx_reg == dcnt_reg)
                    begin
                        idx_reg <= k_reg;
                        state_reg <= S_SCANW;
                    end
                end
                S_SCANW:
                begin
                    rep_reg <= bestv_reg;
                    state_reg <= S_GEMIT;
                end
                S_GEMIT:
                begin
                    // idx_reg stays at k so the tally read keeps the value at k.
                    rep_reg <= rep_reg - 1'b1;
                    if (rep_reg == CW'(1))
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (k_reg + 1'b1 == dcnt_reg)
                            state_reg <= S_CLRW;
                        else
                        begin
                            idx_reg   <= k_reg + 1'b1;
                            found_reg <= 1'b0;
                            bestv_reg <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_CLRW:
                begin
                    len_reg    <= '0;
                    dcnt_reg   <= '0;
                    lvalid_reg <= '0;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Output assembly; in group mode the run of label k ends the word with
    // the last distinct entry.
    always_comb
    begin
        out_v_next = 1'b0;
        out_l_next = 1'b0;
        out_next   = label_at(label_q);
        if (state_reg == S_EMOUT)
        begin
            out_v_next = 1'b1;
            out_l_next = (idx_reg + 1'b1 == len_reg);
        end
        else if (state_reg == S_GEMIT)
        begin
            out_next   = label_at(6'(k_reg));
            out_v_next = 1'b1;
            out_l_next = (rep_reg == CW'(1) && k_reg + 1'b1 == dcnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        canonical_char <= out_next;
        last_out       <= out_l_next;
    end
endmodule
`default_nettype wire

@@ rtl/core/word_pattern_canonicalizer.sv @@
// Top level of the word pattern canonicalizer: APB register file and engine.
// Depends on wpc_pkg and wpc_engine.
`default_nettype none
// A word enters one character per request (start while busy is low) and the
// first MAX_LEN characters are kept. A request whose character is new to the
// word keeps busy high through a label-memory lookup and then a wrap-up
// state before the next request can be taken; a request that repeats a
// character adds a tally read and a tally write-back through the registered
// memory. A dropped character takes only the lookup and the wrap-up state.
// On the request marked last the block emits one label per kept position on
// canonical_char, each shown for one cycle with valid high; last_out marks
// the final label. The receiver cannot stall, so the labels come out while
// busy stays high; in plain order each label passes a word read, a label
// read and an emit state. In group mode each label's run comes out one
// label per cycle after a scan of the tallies not yet used. The per-word
// maps clear in the cycle that shows the final label, and busy falls right
// after it.
module word_pattern_canonicalizer
    import wpc_pkg::*;
#(
    parameter int MAX_LEN = DefMaxLen
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             start,
    input  wire logic [7:0]       character,
    input  wire logic             last_char,
    output logic                  busy,
    output logic                  valid,
    output logic [6:0]            canonical_char,
    output logic                  last_out
);
    logic fold_reg;
    logic group_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg  <= 1'b0;
            group_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == RegFoldCase)
                fold_reg <= pwdata[0];
            else if (paddr == RegGroup)
                group_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == RegFoldCase)
            prdata[0] = fold_reg;
        else if (paddr == RegGroup)
            prdata[0] = group_reg;
    end

    wpc_engine #(.MAX_LEN(MAX_LEN)) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .character      (character),
        .last_char      (last_char),
        .fold_case      (fold_reg),
        .group_by_count (group_reg),
        .busy           (busy),
        .valid          (valid),
        .canonical_char (canonical_char),
        .last_out       (last_out)
    );

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_out && valid |=> !valid || busy)
        else $error("label after final label");
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("label without a word in progress");
endmodule
`default_nettype wire
